>>> hw/rtl/svel_pkg.sv
// ----------------------------------------------------------------------------
// svel_pkg
// Shared types, codes and the quarter-sine gain table of the sampler voice.
// ----------------------------------------------------------------------------
package svel_pkg;

    localparam int MAX_FRAMES  = 65536;
    localparam int ENV_STEPS   = 1024;
    localparam int ADDR_W      = 16;
    localparam int POS_W       = 17;
    localparam int PHASE_W     = 27;
    localparam int STEP_W      = 26;
    localparam int GAIN_W      = 17;
    localparam int ROM_AW      = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 26;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 40;

    localparam logic [GAIN_W-1:0] UNITY = 17'd32768;
    localparam longint unsigned Q30 = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_PLAY = 2'd1;
    localparam logic [1:0] FUNC_STOP = 2'd2;
    localparam logic [1:0] FUNC_TICK = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_FRAMES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_XFADE_FRAMES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_XFADE_STEP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_SEL, S_RD0, S_RD1, S_RD2, S_RD3, S_GM, S_GR,
        S_ML1, S_ML2, S_MR1, S_MR2, S_RL, S_RR, S_FIN
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_ACCEPT, CMD_SEL, CMD_RD0, CMD_RD1, CMD_RD2, CMD_RD3,
        CMD_GM, CMD_GR, CMD_ML1, CMD_ML2, CMD_MR1, CMD_MR2, CMD_RL, CMD_RR,
        CMD_COMMIT
    } t_cmd;

    typedef enum logic [2:0] {
        BR_ATTACK, BR_XFADE, BR_WRAP, BR_END, BR_PLAIN
    } t_branch;

    typedef struct packed {
        logic playing;
        logic out_free;
    } t_status;

    typedef logic [GAIN_W-1:0] t_gain_rom [0:ENV_STEPS];

    function automatic logic [GAIN_W-1:0] sine_gain(input longint unsigned i);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned u;
        longint unsigned g;
        t  = i * HALF_PI_Q30 / ENV_STEPS;
        t2 = (t * t) >> 30;
        u  = Q30 - t2 / 110;
        u  = Q30 - ((t2 * u) >> 30) / 72;
        u  = Q30 - ((t2 * u) >> 30) / 42;
        u  = Q30 - ((t2 * u) >> 30) / 20;
        u  = Q30 - ((t2 * u) >> 30) / 6;
        g  = (((t * u) >> 30) + 64'd16384) >> 15;
        if (g > 64'd32768) begin
            g = 64'd32768;
        end
        return g[GAIN_W-1:0];
    endfunction

    function automatic t_gain_rom gain_rom();
        t_gain_rom r;
        for (int k = 0; k <= ENV_STEPS; k++) begin
            r[k] = sine_gain(longint'(k));
        end
        return r;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_add(input logic [PHASE_W-1:0] p,
                                                     input logic [STEP_W-1:0] s);
        logic [PHASE_W:0] sum;
        sum = {1'b0, p} + {2'b00, s};
        return sum[PHASE_W] ? {PHASE_W{1'b1}} : sum[PHASE_W-1:0];
    endfunction

endpackage

>>> hw/rtl/sample_voice_envelope_loop_core.sv
// ----------------------------------------------------------------------------
// sample_voice_envelope_loop_core
// Stereo sample playback voice with attack, looping crossfade and release.
// ----------------------------------------------------------------------------
// Load, play and stop items are accepted without leaving the idle state. A
// tick while the voice is idle goes straight to commit and gives a zero frame;
// a tick while playing runs a fixed sequence through the sample memory and
// gain ROM read ports and the single shared 18x18 multiplier (two gain
// lookups, four mix products, two release products). A tick waits at its end
// while the previous output frame has not been taken. The sample memory has
// no reset: only frames that were loaded may be played.
module sample_voice_envelope_loop_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [svel_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [svel_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [svel_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // frame_address, left_in, right_in
    input  logic [1:0]                       s_axis_tuser,   // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [svel_pkg::OUT_DATA_W-1:0]  m_axis_tdata    // left_out, right_out, active
);

    svel_pkg::t_cmd    cmd;
    svel_pkg::t_status status;

    svel_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    svel_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule

>>> hw/rtl/svel_ctrl.sv
// ----------------------------------------------------------------------------
// svel_ctrl
// Sequencer of the voice: accepts items and steps the datapath through a tick.
// ----------------------------------------------------------------------------
module svel_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [1:0]        s_axis_tuser,   // func
    input  svel_pkg::t_status i_status,
    output svel_pkg::t_cmd    o_cmd
);

    svel_pkg::t_state r_state;
    svel_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svel_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = svel_pkg::CMD_NONE;
        s_axis_tready = 1'b0;
        case (r_state)
            svel_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd = svel_pkg::CMD_ACCEPT;
                    if (s_axis_tuser == svel_pkg::FUNC_TICK) begin
                        n_state = i_status.playing ? svel_pkg::S_SEL : svel_pkg::S_FIN;
                    end
                end
            end
            svel_pkg::S_SEL: begin o_cmd = svel_pkg::CMD_SEL; n_state = svel_pkg::S_RD0; end
            svel_pkg::S_RD0: begin o_cmd = svel_pkg::CMD_RD0; n_state = svel_pkg::S_RD1; end
            svel_pkg::S_RD1: begin o_cmd = svel_pkg::CMD_RD1; n_state = svel_pkg::S_RD2; end
            svel_pkg::S_RD2: begin o_cmd = svel_pkg::CMD_RD2; n_state = svel_pkg::S_RD3; end
            svel_pkg::S_RD3: begin o_cmd = svel_pkg::CMD_RD3; n_state = svel_pkg::S_GM;  end
            svel_pkg::S_GM:  begin o_cmd = svel_pkg::CMD_GM;  n_state = svel_pkg::S_GR;  end
            svel_pkg::S_GR:  begin o_cmd = svel_pkg::CMD_GR;  n_state = svel_pkg::S_ML1; end
            svel_pkg::S_ML1: begin o_cmd = svel_pkg::CMD_ML1; n_state = svel_pkg::S_ML2; end
            svel_pkg::S_ML2: begin o_cmd = svel_pkg::CMD_ML2; n_state = svel_pkg::S_MR1; end
            svel_pkg::S_MR1: begin o_cmd = svel_pkg::CMD_MR1; n_state = svel_pkg::S_MR2; end
            svel_pkg::S_MR2: begin o_cmd = svel_pkg::CMD_MR2; n_state = svel_pkg::S_RL;  end
            svel_pkg::S_RL:  begin o_cmd = svel_pkg::CMD_RL;  n_state = svel_pkg::S_RR;  end
            svel_pkg::S_RR:  begin o_cmd = svel_pkg::CMD_RR;  n_state = svel_pkg::S_FIN; end
            svel_pkg::S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd   = svel_pkg::CMD_COMMIT;
                    n_state = svel_pkg::S_IDLE;
                end
            end
            default: n_state = svel_pkg::S_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/svel_dp.sv
// ----------------------------------------------------------------------------
// svel_dp
// Voice datapath: sample memory, gain ROM, shared multiplier, voice state.
// ----------------------------------------------------------------------------
module svel_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [svel_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [svel_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [1:0]                          s_axis_tuser,   // func
    input  logic [svel_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // frame_address, left_in, right_in
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [svel_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // left_out, right_out, active
    input  svel_pkg::t_cmd                      i_cmd,
    output svel_pkg::t_status                   o_status
);

    localparam svel_pkg::t_gain_rom GAIN_ROM = svel_pkg::gain_rom();

    // configuration
    logic [svel_pkg::POS_W-1:0]   r_frame_count;
    logic                         r_loop;
    logic [svel_pkg::ADDR_W-1:0]  r_att_frames;
    logic [svel_pkg::STEP_W-1:0]  r_att_step;
    logic [svel_pkg::ADDR_W-1:0]  r_xf_frames;
    logic [svel_pkg::STEP_W-1:0]  r_xf_step;
    logic [svel_pkg::STEP_W-1:0]  r_rel_step;
    logic [svel_pkg::POS_W-1:0]   r_xpoint;

    // voice state
    logic [svel_pkg::POS_W-1:0]   r_pos;
    logic [svel_pkg::PHASE_W-1:0] r_aph;
    logic [svel_pkg::PHASE_W-1:0] r_fph;
    logic [svel_pkg::PHASE_W-1:0] r_rph;
    logic                         r_playing;
    logic                         r_releasing;
    logic                         r_fp;
    logic                         r_out_valid;

    // per-tick working registers
    logic                         r_idle;
    logic                         r_fp_new;
    svel_pkg::t_branch            r_br;
    logic [svel_pkg::ADDR_W-1:0]  r_addr_cur;
    logic [svel_pkg::ADDR_W-1:0]  r_addr_head;
    logic [svel_pkg::PHASE_W-1:0] r_mph;
    logic [31:0]                  r_cur;
    logic [31:0]                  r_head;
    logic [svel_pkg::GAIN_W-1:0]  r_t0;
    logic [svel_pkg::GAIN_W-1:0]  r_t1;
    logic [svel_pkg::GAIN_W-1:0]  r_rt0;
    logic [svel_pkg::GAIN_W-1:0]  r_gm;
    logic [svel_pkg::GAIN_W-1:0]  r_gr;
    logic signed [31:0]           r_acc;
    logic signed [15:0]           r_mix_l;
    logic signed [15:0]           r_mix_r;
    logic signed [15:0]           r_rel_l;
    logic signed [15:0]           r_rel_r;
    logic signed [35:0]           r_prod;
    logic [31:0]                  r_mem_q;
    logic [svel_pkg::GAIN_W-1:0]  r_rom_q;
    logic [svel_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [31:0] mem [0:svel_pkg::MAX_FRAMES-1];

    logic [svel_pkg::ADDR_W-1:0]  in_addr;
    logic [15:0]                  in_left;
    logic [15:0]                  in_right;
    logic                         fp_n;
    svel_pkg::t_branch            br_n;
    logic [svel_pkg::POS_W-1:0]   head_pos;
    logic [svel_pkg::ADDR_W-1:0]  rd_addr;
    logic [svel_pkg::ROM_AW-1:0]  rom_idx;
    logic signed [17:0]           n_mul_a;
    logic signed [17:0]           n_mul_b;
    logic signed [35:0]           lk_term;
    logic [svel_pkg::GAIN_W-1:0]  lk_gain;
    logic [svel_pkg::GAIN_W-1:0]  w_cur;
    logic [svel_pkg::GAIN_W-1:0]  w_head;
    logic signed [31:0]           mix_sum;
    logic signed [31:0]           mix_rnd;
    logic signed [31:0]           rel_rnd;
    logic                         end_stop;
    logic                         rel_stop;
    logic                         any_stop;
    logic [15:0]                  res_l;
    logic [15:0]                  res_r;

    function automatic logic [svel_pkg::ROM_AW-1:0] idx0(input logic [svel_pkg::PHASE_W-1:0] p);
        return p[svel_pkg::PHASE_W-1] ? svel_pkg::ROM_AW'(svel_pkg::ENV_STEPS)
                                      : {1'b0, p[svel_pkg::PHASE_W-2:16]};
    endfunction

    function automatic logic [svel_pkg::ROM_AW-1:0] idx1(input logic [svel_pkg::PHASE_W-1:0] p);
        return p[svel_pkg::PHASE_W-1] ? svel_pkg::ROM_AW'(svel_pkg::ENV_STEPS)
                                      : {1'b0, p[svel_pkg::PHASE_W-2:16]} + 11'd1;
    endfunction

    function automatic logic signed [17:0] sx(input logic [15:0] s);
        return {{2{s[15]}}, s};
    endfunction

    function automatic logic signed [17:0] gx(input logic [svel_pkg::GAIN_W-1:0] g);
        return {1'b0, g};
    endfunction

    function automatic logic signed [17:0] fx(input logic [svel_pkg::PHASE_W-1:0] p);
        return {2'b00, p[15:0]};
    endfunction

    function automatic logic signed [31:0] rnd15(input logic signed [31:0] x);
        return (x + 32'sd16384) >>> 15;
    endfunction

    assign in_addr  = s_axis_tdata[15:0];
    assign in_left  = s_axis_tdata[31:16];
    assign in_right = s_axis_tdata[47:32];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_loop        <= 1'b0;
            r_att_frames  <= '0;
            r_att_step    <= '0;
            r_xf_frames   <= '0;
            r_xf_step     <= '0;
            r_rel_step    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                svel_pkg::CFG_FRAME_COUNT:   r_frame_count <= i_cfg_data[svel_pkg::POS_W-1:0];
                svel_pkg::CFG_LOOP_ENABLE:   r_loop        <= i_cfg_data[0];
                svel_pkg::CFG_ATTACK_FRAMES: r_att_frames  <= i_cfg_data[svel_pkg::ADDR_W-1:0];
                svel_pkg::CFG_ATTACK_STEP:   r_att_step    <= i_cfg_data;
                svel_pkg::CFG_XFADE_FRAMES:  r_xf_frames   <= i_cfg_data[svel_pkg::ADDR_W-1:0];
                svel_pkg::CFG_XFADE_STEP:    r_xf_step     <= i_cfg_data;
                svel_pkg::CFG_RELEASE_STEP:  r_rel_step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_xpoint <= (r_frame_count > {1'b0, r_xf_frames})
                    ? r_frame_count - {1'b0, r_xf_frames} : '0;
    end

    // branch select
    always_comb begin
        fp_n     = r_fp & ~(r_loop & (r_pos > {1'b0, r_att_frames}));
        head_pos = r_pos - r_xpoint;
        if (fp_n && (r_pos < {1'b0, r_att_frames}) && (r_pos < r_frame_count)) begin
            br_n = svel_pkg::BR_ATTACK;
        end else if (r_loop && (r_pos >= r_xpoint) && (r_pos < r_frame_count)) begin
            br_n = svel_pkg::BR_XFADE;
        end else if (r_pos >= r_frame_count) begin
            br_n = r_loop ? svel_pkg::BR_WRAP : svel_pkg::BR_END;
        end else begin
            br_n = svel_pkg::BR_PLAIN;
        end
    end

    // memory and ROM addressing
    always_comb begin
        rd_addr = (i_cmd == svel_pkg::CMD_RD1) ? r_addr_head : r_addr_cur;
        case (i_cmd)
            svel_pkg::CMD_RD0: rom_idx = idx0(r_mph);
            svel_pkg::CMD_RD1: rom_idx = idx1(r_mph);
            svel_pkg::CMD_RD2: rom_idx = idx0(r_rph);
            svel_pkg::CMD_RD3: rom_idx = idx1(r_rph);
            default:           rom_idx = idx0(r_rph);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == svel_pkg::CMD_ACCEPT && s_axis_tuser == svel_pkg::FUNC_LOAD) begin
            mem[in_addr] <= {in_right, in_left};
        end
        r_mem_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rom_q <= GAIN_ROM[rom_idx];
    end

    // weights and shared multiplier
    always_comb begin
        case (r_br)
            svel_pkg::BR_ATTACK: begin w_cur = r_gm;         w_head = '0;   end
            svel_pkg::BR_XFADE:  begin w_cur = svel_pkg::UNITY - r_gm; w_head = r_gm; end
            default:             begin w_cur = svel_pkg::UNITY; w_head = '0;  end
        endcase
        lk_term = (r_prod + 36'sd32768) >>> 16;
        lk_gain = r_t0 + lk_term[svel_pkg::GAIN_W-1:0];
        mix_sum = r_acc + r_prod[31:0];
        mix_rnd = rnd15(mix_sum);
        rel_rnd = rnd15(r_prod[31:0]);
        n_mul_a = '0;
        n_mul_b = '0;
        case (i_cmd)
            svel_pkg::CMD_RD3: begin n_mul_a = gx(r_t1) - gx(r_t0); n_mul_b = fx(r_mph); end
            svel_pkg::CMD_GM:  begin n_mul_a = gx(r_rom_q) - gx(r_rt0); n_mul_b = fx(r_rph); end
            svel_pkg::CMD_GR:  begin n_mul_a = sx(r_cur[15:0]);   n_mul_b = gx(w_cur);  end
            svel_pkg::CMD_ML1: begin n_mul_a = sx(r_head[15:0]);  n_mul_b = gx(w_head); end
            svel_pkg::CMD_ML2: begin n_mul_a = sx(r_cur[31:16]);  n_mul_b = gx(w_cur);  end
            svel_pkg::CMD_MR1: begin n_mul_a = sx(r_head[31:16]); n_mul_b = gx(w_head); end
            svel_pkg::CMD_MR2: begin n_mul_a = sx(r_mix_l);       n_mul_b = gx(r_gr);   end
            svel_pkg::CMD_RL:  begin n_mul_a = sx(r_mix_r);       n_mul_b = gx(r_gr);   end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_mul_a * n_mul_b;
    end

    // per-tick working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            svel_pkg::CMD_ACCEPT: r_idle <= ~r_playing;
            svel_pkg::CMD_SEL: begin
                r_fp_new    <= fp_n;
                r_br        <= br_n;
                r_addr_cur  <= (br_n == svel_pkg::BR_WRAP) ? r_xf_frames
                                                           : r_pos[svel_pkg::ADDR_W-1:0];
                r_addr_head <= head_pos[svel_pkg::ADDR_W-1:0];
                r_mph       <= (br_n == svel_pkg::BR_XFADE) ? r_fph : r_aph;
            end
            svel_pkg::CMD_RD1: begin r_cur  <= r_mem_q; r_t0 <= r_rom_q; end
            svel_pkg::CMD_RD2: begin r_head <= r_mem_q; r_t1 <= r_rom_q; end
            svel_pkg::CMD_RD3: r_rt0 <= r_rom_q;
            svel_pkg::CMD_GM:  r_gm  <= lk_gain;
            svel_pkg::CMD_GR:  r_gr  <= svel_pkg::UNITY - (r_rt0 + lk_term[svel_pkg::GAIN_W-1:0]);
            svel_pkg::CMD_ML1: r_acc <= r_prod[31:0];
            svel_pkg::CMD_ML2: r_mix_l <= mix_rnd[15:0];
            svel_pkg::CMD_MR1: r_acc <= r_prod[31:0];
            svel_pkg::CMD_MR2: r_mix_r <= mix_rnd[15:0];
            svel_pkg::CMD_RL:  r_rel_l <= rel_rnd[15:0];
            svel_pkg::CMD_RR:  r_rel_r <= rel_rnd[15:0];
            default: ;
        endcase
    end

    // commit
    always_comb begin
        end_stop = (r_br == svel_pkg::BR_END);
        rel_stop = r_releasing & ~end_stop & r_rph[svel_pkg::PHASE_W-1];
        any_stop = end_stop | rel_stop;
        if (any_stop) begin
            res_l = '0;
            res_r = '0;
        end else if (r_releasing) begin
            res_l = r_rel_l;
            res_r = r_rel_r;
        end else begin
            res_l = r_mix_l;
            res_r = r_mix_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_aph       <= '0;
            r_fph       <= '0;
            r_rph       <= '0;
            r_playing   <= 1'b0;
            r_releasing <= 1'b0;
            r_fp        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd == svel_pkg::CMD_COMMIT) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd == svel_pkg::CMD_ACCEPT) begin
                if (s_axis_tuser == svel_pkg::FUNC_PLAY) begin
                    r_playing <= 1'b1;
                end
                if (s_axis_tuser == svel_pkg::FUNC_STOP) begin
                    r_releasing <= 1'b1;
                end
            end
            if (i_cmd == svel_pkg::CMD_COMMIT) begin
                if (r_idle) begin
                    r_out_data <= '0;
                end else begin
                    r_out_data <= {7'd0, ~any_stop, res_r, res_l};
                    if (any_stop) begin
                        r_pos       <= '0;
                        r_aph       <= '0;
                        r_fph       <= '0;
                        r_rph       <= '0;
                        r_playing   <= 1'b0;
                        r_releasing <= 1'b0;
                        r_fp        <= 1'b1;
                    end else begin
                        r_fp <= r_fp_new;
                        case (r_br)
                            svel_pkg::BR_ATTACK: begin
                                r_pos <= r_pos + 17'd1;
                                r_aph <= svel_pkg::phase_add(r_aph, r_att_step);
                            end
                            svel_pkg::BR_XFADE: begin
                                r_pos <= r_pos + 17'd1;
                                r_fph <= svel_pkg::phase_add(r_fph, r_xf_step);
                            end
                            svel_pkg::BR_WRAP: begin
                                r_pos <= {1'b0, r_xf_frames} + 17'd1;
                                r_fph <= '0;
                            end
                            default: r_pos <= r_pos + 17'd1;
                        endcase
                        if (r_releasing) begin
                            r_rph <= svel_pkg::phase_add(r_rph, r_rel_step);
                        end
                    end
                end
            end
        end
    end

    assign m_axis_tvalid     = r_out_valid;
    assign m_axis_tdata      = r_out_data;
    assign o_status.playing  = r_playing;
    assign o_status.out_free = ~r_out_valid | m_axis_tready;

endmodule

>>> sim/svel_voice_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svel_voice_checker
// Watches the config port and both streams of the sampler voice, keeps its
// own copy of the voice state and sample memory, predicts every tick frame
// and compares each output frame field by field in order.
// ----------------------------------------------------------------------------
module svel_voice_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [svel_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [svel_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [svel_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic [1:0]                       i_in_func,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [svel_pkg::OUT_DATA_W-1:0]  i_out_data,
    output int                               o_errors,
    output int                               o_pending
);
    import svel_pkg::*;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic        active;
    } t_frame;

    localparam logic [26:0] PHASE_TOP = 27'h7FF_FFFF;
    localparam logic [26:0] REL_LIMIT_PHASE = 27'd1024 << 16;

    t_frame      frames_due[$];
    logic [15:0] mem_left  [0:65535];
    logic [15:0] mem_right [0:65535];
    int unsigned sine_tab  [0:1024];

    logic [16:0] fc_reg;
    logic        loop_reg;
    logic [15:0] atk_frames_reg, xf_frames_reg;
    logic [25:0] atk_step_reg, xf_step_reg, rel_step_reg;

    logic [16:0] pos;
    logic [26:0] atk_ph, xf_ph, rel_ph;
    logic        playing, releasing, first_pass;

    int errors = 0;
    assign o_errors  = errors;
    assign o_pending = frames_due.size();

    function automatic int unsigned quarter_sine(longint unsigned k);
        longint unsigned t, t2, u, g;
        t  = k * 64'd1686629713 / 1024;
        t2 = (t * t) >> 30;
        u  = 64'd1073741824 - t2 / 110;
        u  = 64'd1073741824 - ((t2 * u) >> 30) / 72;
        u  = 64'd1073741824 - ((t2 * u) >> 30) / 42;
        u  = 64'd1073741824 - ((t2 * u) >> 30) / 20;
        u  = 64'd1073741824 - ((t2 * u) >> 30) / 6;
        g  = (((t * u) >> 30) + 64'd16384) >> 15;
        return (g > 64'd32768) ? 32768 : int'(g);
    endfunction

    function automatic longint gain_at(logic [26:0] ph);
        longint unsigned y, f;
        y = ph >> 16;
        f = ph[15:0];
        if (y >= 1024) return sine_tab[1024];
        return longint'((longint'(sine_tab[y]) * (65536 - f)
                         + longint'(sine_tab[y + 1]) * f + 32768) >> 16);
    endfunction

    function automatic logic [26:0] advance(logic [26:0] p, logic [25:0] s);
        logic [27:0] sum;
        sum = {1'b0, p} + {2'b00, s};
        return sum[27] ? PHASE_TOP : sum[26:0];
    endfunction

    function automatic longint q15(longint sum);
        return (sum + 16384) >>> 15;
    endfunction

    task automatic voice_off();
        pos = 0; atk_ph = 0; xf_ph = 0; rel_ph = 0;
        playing = 0; releasing = 0; first_pass = 1;
    endtask

    task automatic predict_tick();
        t_frame f;
        longint l, r, g;
        logic [16:0] xpoint;
        logic [15:0] a, h;
        if (!playing) begin
            f = '{16'd0, 16'd0, 1'b0};
            frames_due.push_back(f);
            return;
        end
        if (loop_reg && pos > {1'b0, atk_frames_reg}) first_pass = 0;
        xpoint = (fc_reg > {1'b0, xf_frames_reg}) ? fc_reg - xf_frames_reg : 17'd0;
        a = pos[15:0];
        if (first_pass && pos < {1'b0, atk_frames_reg} && pos < fc_reg) begin
            g = gain_at(atk_ph);
            l = q15(longint'($signed(mem_left[a])) * g);
            r = q15(longint'($signed(mem_right[a])) * g);
            pos = pos + 1;
            atk_ph = advance(atk_ph, atk_step_reg);
        end else if (loop_reg && pos >= xpoint && pos < fc_reg) begin
            g = gain_at(xf_ph);
            h = 16'(pos - xpoint);
            l = q15(longint'($signed(mem_left[a])) * (32768 - g)
                    + longint'($signed(mem_left[h])) * g);
            r = q15(longint'($signed(mem_right[a])) * (32768 - g)
                    + longint'($signed(mem_right[h])) * g);
            pos = pos + 1;
            xf_ph = advance(xf_ph, xf_step_reg);
        end else if (pos >= fc_reg) begin
            if (loop_reg) begin
                l = $signed(mem_left[xf_frames_reg]);
                r = $signed(mem_right[xf_frames_reg]);
                pos = {1'b0, xf_frames_reg} + 17'd1;
                xf_ph = 0;
            end else begin
                l = 0; r = 0;
                voice_off();
            end
        end else begin
            l = $signed(mem_left[a]);
            r = $signed(mem_right[a]);
            pos = pos + 1;
        end
        if (releasing) begin
            if (rel_ph >= REL_LIMIT_PHASE) begin
                voice_off();
                l = 0; r = 0;
            end else begin
                g = 32768 - gain_at(rel_ph);
                l = q15(l * g);
                r = q15(r * g);
                rel_ph = advance(rel_ph, rel_step_reg);
            end
        end
        f.left = l[15:0];
        f.right = r[15:0];
        f.active = playing;
        frames_due.push_back(f);
    endtask

    initial begin
        for (int k = 0; k <= 1024; k++) sine_tab[k] = quarter_sine(k);
    end

    always @(posedge i_clk) begin
        t_frame want;
        logic [15:0] got_l, got_r;
        logic        got_a;
        if (!i_rst_n) begin
            voice_off();
            fc_reg = 0; loop_reg = 0; atk_frames_reg = 0; atk_step_reg = 0;
            xf_frames_reg = 0; xf_step_reg = 0; rel_step_reg = 0;
            frames_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FRAME_COUNT:   fc_reg = i_cfg_data[16:0];
                    CFG_LOOP_ENABLE:   loop_reg = i_cfg_data[0];
                    CFG_ATTACK_FRAMES: atk_frames_reg = i_cfg_data[15:0];
                    CFG_ATTACK_STEP:   atk_step_reg = i_cfg_data[25:0];
                    CFG_XFADE_FRAMES:  xf_frames_reg = i_cfg_data[15:0];
                    CFG_XFADE_STEP:    xf_step_reg = i_cfg_data[25:0];
                    CFG_RELEASE_STEP:  rel_step_reg = i_cfg_data[25:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got_l = i_out_data[15:0];
                got_r = i_out_data[31:16];
                got_a = i_out_data[32];
                if (frames_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected frame L=%0d R=%0d active=%0b",
                                 $signed(got_l), $signed(got_r), got_a);
                end else begin
                    want = frames_due.pop_front();
                    if (want.left !== got_l || want.right !== got_r
                            || want.active !== got_a) begin
                        errors++;
                        if (errors <= 10)
                            $display("frame mismatch: exp L=%0d R=%0d A=%0b got L=%0d R=%0d A=%0b",
                                     $signed(want.left), $signed(want.right), want.active,
                                     $signed(got_l), $signed(got_r), got_a);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_func)
                    FUNC_LOAD: begin
                        mem_left[i_in_data[15:0]]  = i_in_data[31:16];
                        mem_right[i_in_data[15:0]] = i_in_data[47:32];
                    end
                    FUNC_PLAY: playing = 1;
                    FUNC_STOP: releasing = 1;
                    default:   predict_tick();
                endcase
            end
        end
    end

    final begin
        if (frames_due.size() != 0) $display("%0d frames never arrived", frames_due.size());
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sampler voice: loads the low frames of the sample memory,
// then runs phases of load, play, stop and tick items under several register
// settings with bursty input and a stalling output; the checker judges every
// frame.
// ----------------------------------------------------------------------------
module tb;
    import svel_pkg::*;

    localparam int WATCH_LIMIT = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = FUNC_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int errors, pending;
    int burst_left = 0;
    int idle_cycles = 0;
    int rx_hold = 0;
    bit rx_steady = 0;

    sample_voice_envelope_loop_core DUT (.*);

    svel_voice_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_func(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rx_steady) begin
            m_axis_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0) rx_hold <= $urandom_range(1, 12);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] func, logic [15:0] addr,
                             logic [15:0] left, logic [15:0] right);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {right, left, addr};
        s_axis_tuser  <= func;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random(int tick_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < tick_pct)
            send_item(FUNC_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < tick_pct + 8)
            send_item(FUNC_PLAY, 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < tick_pct + 12)
            send_item(FUNC_STOP, 16'($urandom), 16'($urandom), 16'($urandom));
        else
            send_item(FUNC_LOAD, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic set_voice(logic [16:0] fc, logic lp, logic [15:0] af, logic [25:0] ast,
                             logic [15:0] xf, logic [25:0] xst, logic [25:0] rst);
        logic [CFG_DATA_W-1:0] vals [7];
        vals = '{26'(fc), 26'(lp), 26'(af), ast, 26'(xf), xst, rst};
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        for (int k = 0; k < 7; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(k);
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [25:0] rand_step();
        return 26'($urandom_range(0, 26'h3FF_FFFF) >> $urandom_range(0, 14));
    endfunction

    initial begin
        logic [16:0] fc;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // play positions stay below 128 in every phase
        for (int a = 0; a < 128; a++) begin
            case (a)
                0:       send_item(FUNC_LOAD, 16'(a), 16'h7FFF, 16'h8000);
                1:       send_item(FUNC_LOAD, 16'(a), 16'h8000, 16'h7FFF);
                default: send_item(FUNC_LOAD, 16'(a), 16'($urandom), 16'($urandom));
            endcase
        end
        send_item(FUNC_LOAD, 16'hFFFF, 16'hFFFF, 16'h0000);

        set_voice(17'd8, 1'b1, 16'd4, 26'h40_0000, 16'd3, 26'h80_0000, 26'h40_0000);
        send_item(FUNC_TICK, 16'd0, 16'd0, 16'd0);
        send_item(FUNC_STOP, 16'd0, 16'd0, 16'd0);
        send_item(FUNC_TICK, 16'd0, 16'd0, 16'd0);
        send_item(FUNC_PLAY, 16'd0, 16'd0, 16'd0);
        repeat (6) send_item(FUNC_TICK, 16'd0, 16'd0, 16'd0);
        send_item(FUNC_PLAY, 16'd0, 16'd0, 16'd0);
        repeat (14) send_item(FUNC_TICK, 16'd0, 16'd0, 16'd0);

        set_voice(17'd0, 1'b0, 16'd0, 26'd0, 16'd0, 26'd0, 26'd0);
        send_item(FUNC_PLAY, 16'd0, 16'd0, 16'd0);
        repeat (3) send_item(FUNC_TICK, 16'd0, 16'd0, 16'd0);
        for (int k = 0; k < 60; k++) send_random(60);

        rx_steady = 1;
        set_voice(17'd65536, 1'b1, 16'hFFFF, 26'h3FF_FFFF, 16'hFFFF,
                  26'h3FF_FFFF, 26'h3FF_FFFF);
        send_item(FUNC_PLAY, 16'd0, 16'd0, 16'd0);
        for (int k = 0; k < 60; k++) send_random(70);
        rx_steady = 0;

        set_voice(17'd65535, 1'b0, 16'd20, rand_step(), 16'd65535, rand_step(), 26'd0);
        send_item(FUNC_PLAY, 16'd0, 16'd0, 16'd0);
        for (int k = 0; k < 60; k++) send_random(75);

        set_voice(17'd12, 1'b1, 16'd0, 26'd0, 16'd30, 26'h10_0000, 26'h20_0000);
        for (int k = 0; k < 60; k++) send_random(70);

        for (int p = 0; p < 8; p++) begin
            rx_steady = ($urandom_range(0, 3) == 0);
            fc = 17'($urandom_range(1, 40));
            set_voice(fc, 1'($urandom), 16'($urandom_range(0, fc + 4)), rand_step(),
                      16'($urandom_range(0, fc + 3)), rand_step(), rand_step());
            for (int k = 0; k < 45; k++) send_random(70);
        end
        rx_steady = 0;

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
